### hw/rtl/gcs_pkg.sv
package gcs_pkg;

   localparam int unsigned PixW  = 8;
   localparam int unsigned GainW = 16;
   localparam int unsigned OffW  = 10;
   localparam int unsigned CmdW  = 2;
   localparam int unsigned IdxW  = 2;
   localparam int unsigned AccW  = GainW + PixW;
   localparam int unsigned NumW  = 2 * PixW;
   localparam int unsigned CntW  = 4;

   localparam logic [CntW-1:0] StepCount = CntW'(PixW);

   localparam logic [CmdW-1:0] CMD_CLEAR   = 2'd0;
   localparam logic [CmdW-1:0] CMD_MEASURE = 2'd1;
   localparam logic [CmdW-1:0] CMD_MAP     = 2'd2;

   localparam logic [IdxW-1:0] REG_MODE   = 2'd0;
   localparam logic [IdxW-1:0] REG_GAIN   = 2'd1;
   localparam logic [IdxW-1:0] REG_OFFSET = 2'd2;

   localparam logic              MODE_RESET   = 1'b1;
   localparam logic [GainW-1:0]  GAIN_RESET   = 16'd113;
   localparam logic [OffW-1:0]   OFFSET_RESET = 10'd30;
   localparam logic [PixW-1:0]   PIX_MAX      = 8'hFF;
   localparam logic [PixW-1:0]   PIX_MIN      = 8'h00;

   typedef struct packed {
      logic            start;
      logic            is_div;
      logic [GainW-1:0] gain;
      logic [PixW-1:0] mul_op;
      logic [NumW-1:0] dividend;
      logic [PixW-1:0] divisor;
   } unit_cmd_type;

   typedef struct packed {
      logic            done;
      logic [AccW-1:0] acc;
      logic [PixW-1:0] quot;
   } unit_status_type;

endpackage

### hw/rtl/gcs_serial_unit.sv
module gcs_serial_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  gcs_pkg::unit_cmd_type    cmd,
   output gcs_pkg::unit_status_type status
);

   logic [gcs_pkg::CntW-1:0]  count_ff, count_in;
   logic                      is_div_ff, is_div_in;
   logic [gcs_pkg::PixW-1:0]  op_ff, op_in;
   logic [gcs_pkg::GainW-1:0] gain_ff, gain_in;
   logic [gcs_pkg::AccW-1:0]  acc_ff, acc_in;
   logic [gcs_pkg::PixW-1:0]  den_ff, den_in;

   logic [gcs_pkg::PixW:0]    trial;
   logic [gcs_pkg::PixW:0]    trial_diff;
   logic                      fits;
   logic                      stepping;

   assign stepping   = (count_ff != gcs_pkg::StepCount);
   assign trial      = {acc_ff[gcs_pkg::PixW-1:0], op_ff[gcs_pkg::PixW-1]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign fits       = (trial >= {1'b0, den_ff});

   always_comb begin
      count_in  = count_ff;
      is_div_in = is_div_ff;
      op_in     = op_ff;
      gain_in   = gain_ff;
      acc_in    = acc_ff;
      den_in    = den_ff;
      if (cmd.start) begin
         count_in  = '0;
         is_div_in = cmd.is_div;
         gain_in   = cmd.gain;
         den_in    = cmd.divisor;
         if (cmd.is_div) begin
            // upper dividend half is the starting remainder, below the divisor
            acc_in = {{(gcs_pkg::AccW-gcs_pkg::PixW){1'b0}},
                      cmd.dividend[gcs_pkg::NumW-1:gcs_pkg::PixW]};
            op_in  = cmd.dividend[gcs_pkg::PixW-1:0];
         end else begin
            acc_in = '0;
            op_in  = cmd.mul_op;
         end
      end else if (stepping) begin
         count_in = count_ff + 1'b1;
         if (is_div_ff) begin
            // restoring step: shift in the next dividend bit, quotient bit out
            acc_in = {{(gcs_pkg::AccW-gcs_pkg::PixW){1'b0}},
                      fits ? trial_diff[gcs_pkg::PixW-1:0] : trial[gcs_pkg::PixW-1:0]};
            op_in  = {op_ff[gcs_pkg::PixW-2:0], fits};
         end else begin
            // shift-add, multiplier bits taken MSB first
            acc_in = {acc_ff[gcs_pkg::AccW-2:0], 1'b0}
                   + (op_ff[gcs_pkg::PixW-1] ? {{gcs_pkg::PixW{1'b0}}, gain_ff}
                                             : {gcs_pkg::AccW{1'b0}});
            op_in  = {op_ff[gcs_pkg::PixW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= gcs_pkg::StepCount;
      end else begin
         count_ff <= count_in;
      end
      is_div_ff <= is_div_in;
      op_ff     <= op_in;
      gain_ff   <= gain_in;
      acc_ff    <= acc_in;
      den_ff    <= den_in;
   end

   assign status.done = !stepping;
   assign status.acc  = acc_ff;
   assign status.quot = op_ff;

endmodule

### hw/rtl/gray_contrast_stretch_unit.sv
// Channel  Direction  Ports                                     Transfer
// req      in         req_valid req_ready req_command req_pixel  valid & ready
// rsp      out        rsp_valid rsp_ready rsp_pixel_out          valid & ready
//                     rsp_flat_range
// csr      in         csr_wen csr_index csr_wdata                 csr_wen
//
// Clear, measure and unused commands complete in the cycle they transfer, no result.
// A map runs 8 bit-serial steps of the shift-add multiplier (linear mode)
// or restoring divider (min-max mode), then the result loads the output register.
// A map is accepted while the previous result waits; it holds at its last step until
// the output register is free. Reset is synchronous and restores the CSRs, stats and flags.
module gray_contrast_stretch_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [gcs_pkg::CmdW-1:0]   req_command,
   input  logic [gcs_pkg::PixW-1:0]   req_pixel,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [gcs_pkg::PixW-1:0]   rsp_pixel_out,
   output logic                       rsp_flat_range,
   input  logic                       csr_wen,
   input  logic [gcs_pkg::IdxW-1:0]   csr_index,
   input  logic [gcs_pkg::GainW-1:0]  csr_wdata
);

   localparam int unsigned SumW = gcs_pkg::AccW + 2;

   logic                       mode_ff, mode_in;
   logic [gcs_pkg::GainW-1:0]  gain_ff, gain_in;
   logic [gcs_pkg::OffW-1:0]   offset_ff, offset_in;
   logic [gcs_pkg::PixW-1:0]   low_seen_ff, low_seen_in;
   logic [gcs_pkg::PixW-1:0]   high_seen_ff, high_seen_in;

   logic                       busy_ff, busy_in;
   logic                       op_mode_ff, op_mode_in;
   logic                       spec_ff, spec_in;
   logic [gcs_pkg::PixW-1:0]   spec_val_ff, spec_val_in;
   logic                       flat_ff, flat_in;
   logic [gcs_pkg::OffW-1:0]   op_offset_ff, op_offset_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [gcs_pkg::PixW-1:0]   rsp_pixel_out_ff, rsp_pixel_out_in;
   logic                       rsp_flat_range_ff, rsp_flat_range_in;

   gcs_pkg::unit_cmd_type      unit_cmd;
   gcs_pkg::unit_status_type   unit_status;

   logic                       req_transfer;
   logic                       map_transfer;
   logic                       range_flat;
   logic [gcs_pkg::PixW-1:0]   diff;
   logic [SumW-1:0]            lin_sum;
   logic [gcs_pkg::PixW-1:0]   lin_val;
   logic [gcs_pkg::PixW-1:0]   final_val;
   logic                       finish;

   assign req_ready    = !busy_ff;
   assign req_transfer = req_valid && req_ready;
   assign map_transfer = req_transfer && (req_command == gcs_pkg::CMD_MAP);

   assign range_flat = (high_seen_ff <= low_seen_ff);
   assign diff       = req_pixel - low_seen_ff;

   assign unit_cmd.start    = map_transfer;
   assign unit_cmd.is_div   = mode_ff;
   assign unit_cmd.gain     = gain_ff;
   assign unit_cmd.mul_op   = req_pixel;
   // 255 * diff, as diff * 256 - diff
   assign unit_cmd.dividend = {diff, {gcs_pkg::PixW{1'b0}}}
                            - {{gcs_pkg::PixW{1'b0}}, diff};
   assign unit_cmd.divisor  = high_seen_ff - low_seen_ff;

   gcs_serial_unit u_serial (
      .clock  (clock),
      .reset  (reset),
      .cmd    (unit_cmd),
      .status (unit_status)
   );

   // product plus offset * 256, signed
   assign lin_sum = {2'b00, unit_status.acc}
                  + {{(SumW-gcs_pkg::OffW-gcs_pkg::PixW){op_offset_ff[gcs_pkg::OffW-1]}},
                     op_offset_ff, {gcs_pkg::PixW{1'b0}}};

   always_comb begin
      if (lin_sum[SumW-1]) begin
         lin_val = gcs_pkg::PIX_MIN;
      end else if (|lin_sum[SumW-2:2*gcs_pkg::PixW]) begin
         lin_val = gcs_pkg::PIX_MAX;
      end else begin
         lin_val = lin_sum[2*gcs_pkg::PixW-1:gcs_pkg::PixW];
      end
   end

   always_comb begin
      if (!op_mode_ff) begin
         final_val = lin_val;
      end else if (spec_ff) begin
         final_val = spec_val_ff;
      end else begin
         final_val = unit_status.quot;
      end
   end

   assign finish = busy_ff && unit_status.done && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      mode_in      = mode_ff;
      gain_in      = gain_ff;
      offset_in    = offset_ff;
      low_seen_in  = low_seen_ff;
      high_seen_in = high_seen_ff;
      busy_in      = busy_ff;
      op_mode_in   = op_mode_ff;
      spec_in      = spec_ff;
      spec_val_in  = spec_val_ff;
      flat_in      = flat_ff;
      op_offset_in = op_offset_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_pixel_out_in  = rsp_pixel_out_ff;
      rsp_flat_range_in = rsp_flat_range_ff;

      if (csr_wen) begin
         case (csr_index)
            gcs_pkg::REG_MODE:   mode_in   = csr_wdata[0];
            gcs_pkg::REG_GAIN:   gain_in   = csr_wdata;
            gcs_pkg::REG_OFFSET: offset_in = csr_wdata[gcs_pkg::OffW-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (finish) begin
         busy_in           = 1'b0;
         rsp_valid_in      = 1'b1;
         rsp_pixel_out_in  = final_val;
         rsp_flat_range_in = op_mode_ff && flat_ff;
      end

      if (req_transfer) begin
         case (req_command)
            gcs_pkg::CMD_CLEAR: begin
               low_seen_in  = gcs_pkg::PIX_MAX;
               high_seen_in = gcs_pkg::PIX_MIN;
            end
            gcs_pkg::CMD_MEASURE: begin
               if (req_pixel < low_seen_ff) low_seen_in = req_pixel;
               if (req_pixel > high_seen_ff) high_seen_in = req_pixel;
            end
            gcs_pkg::CMD_MAP: begin
               busy_in      = 1'b1;
               op_mode_in   = mode_ff;
               op_offset_in = offset_ff;
               flat_in      = range_flat;
               // resolve flat range and out-of-range pixels up front
               if (range_flat) begin
                  spec_in     = 1'b1;
                  spec_val_in = req_pixel;
               end else if (req_pixel <= low_seen_ff) begin
                  spec_in     = 1'b1;
                  spec_val_in = gcs_pkg::PIX_MIN;
               end else if (req_pixel >= high_seen_ff) begin
                  spec_in     = 1'b1;
                  spec_val_in = gcs_pkg::PIX_MAX;
               end else begin
                  spec_in     = 1'b0;
                  spec_val_in = gcs_pkg::PIX_MIN;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= gcs_pkg::MODE_RESET;
         gain_ff      <= gcs_pkg::GAIN_RESET;
         offset_ff    <= gcs_pkg::OFFSET_RESET;
         low_seen_ff  <= gcs_pkg::PIX_MAX;
         high_seen_ff <= gcs_pkg::PIX_MIN;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         gain_ff      <= gain_in;
         offset_ff    <= offset_in;
         low_seen_ff  <= low_seen_in;
         high_seen_ff <= high_seen_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_mode_ff        <= op_mode_in;
      spec_ff           <= spec_in;
      spec_val_ff       <= spec_val_in;
      flat_ff           <= flat_in;
      op_offset_ff      <= op_offset_in;
      rsp_pixel_out_ff  <= rsp_pixel_out_in;
      rsp_flat_range_ff <= rsp_flat_range_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_out_ff;
   assign rsp_flat_range = rsp_flat_range_ff;

   a_map_starts_work: assert property (@(posedge clock) disable iff (reset)
      map_transfer |=> busy_ff && !unit_status.done)
      else $error("map transfer did not start the serial unit");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff && unit_status.done))
      else $error("result appeared without a finished map");

   a_quotient_in_range: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && unit_status.done && op_mode_ff && !spec_ff) |-> (unit_status.quot != gcs_pkg::PIX_MAX))
      else $error("stretch quotient reached full scale inside the range");

   a_flat_only_stretch: assert property (@(posedge clock) disable iff (reset)
      finish && !op_mode_ff |=> !rsp_flat_range_ff)
      else $error("flat flag raised in linear mode");

endmodule
